// File: rtl/wwpc_pkg.sv
// ----------------------------------------------------------------------------
// wwpc_pkg
// Shared widths, sizes and register codes of the weight window piece counter.
// ----------------------------------------------------------------------------
package wwpc_pkg;

  // Number of totals in the moving-average ring (2 .. 64)
  localparam int unsigned WINDOW   = 10;
  localparam int unsigned SLOT_W   = $clog2(WINDOW);

  localparam int unsigned RAW_W    = 24;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = RAW_W + GAIN_W;
  localparam int unsigned GRAM_W   = 20;
  localparam int unsigned TOTAL_W  = GRAM_W + 1;
  localparam int unsigned SUM_W    = TOTAL_W + $clog2(WINDOW);
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CHANGE_W = COUNT_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W + 1);

  // Window average as (sum * AVG_RECIP) >> AVG_SHIFT, exact for any SUM_W-bit sum
  localparam int unsigned     AVG_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int unsigned     RECIP_W   = SUM_W + 1;
  localparam longint unsigned AVG_RECIP = ((64'd1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] STATUS_MEASURING = 2'd0;
  localparam logic [1:0] STATUS_STABLE    = 2'd1;
  localparam logic [1:0] STATUS_ADDED     = 2'd2;
  localparam logic [1:0] STATUS_REMOVED   = 2'd3;

  typedef enum logic [2:0] {
    REG_TARE_A       = 3'd0,
    REG_TARE_B       = 3'd1,
    REG_GAIN_A       = 3'd2,
    REG_GAIN_B       = 3'd3,
    REG_UNIT_WEIGHT  = 3'd4,
    REG_MIN_WEIGHT   = 3'd5,
    REG_STEADY_LIMIT = 3'd6,
    REG_MAX_WEIGHT   = 3'd7
  } reg_idx_e;

endpackage

// File: rtl/weight_window_piece_counter_top.sv
// ----------------------------------------------------------------------------
// weight_window_piece_counter_top
// Two-cell counting scale: grams conversion, moving-average window,
// stability check and piece counting.
// ----------------------------------------------------------------------------
// An input transaction with sensors_ready low is accepted in S_IDLE and gives
// no result. A ready transaction is followed by two walks over the window
// memory (one read per cycle), a reciprocal multiplication for the window
// average and one pass of the bit-serial divider for the piece count before
// the next one is accepted; the deviation walk overlaps the division and stays
// hidden behind it while WINDOW does not exceed SUM_W + 1. The finished result
// sits in an output register, so the next input transaction is accepted while
// it waits. The window memory needs no clearing pass: a valid bit per entry
// makes unwritten entries read as zero.
// ----------------------------------------------------------------------------
module weight_window_piece_counter_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [wwpc_pkg::RAW_W-1:0]  raw_sample_a_i,
  input  logic signed [wwpc_pkg::RAW_W-1:0]  raw_sample_b_i,
  input  logic                               sensors_ready_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [wwpc_pkg::GRAM_W-1:0]        cell_weight_a_o,
  output logic [wwpc_pkg::GRAM_W-1:0]        cell_weight_b_o,
  output logic [wwpc_pkg::GRAM_W-1:0]        average_weight_o,
  output logic [wwpc_pkg::COUNT_W-1:0]       piece_count_o,
  output logic                               steady_o,
  output logic [1:0]                         status_o,
  output logic signed [wwpc_pkg::CHANGE_W-1:0] count_change_o,
  output logic                               over_capacity_o,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wwpc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [wwpc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [wwpc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int unsigned GW = wwpc_pkg::GRAM_W;
  localparam int unsigned TW = wwpc_pkg::TOTAL_W;
  localparam int unsigned SW = wwpc_pkg::SLOT_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MULA  = 11'b000_0000_0010,
    S_MULB  = 11'b000_0000_0100,
    S_SATB  = 11'b000_0000_1000,
    S_WRITE = 11'b000_0001_0000,
    S_SUM   = 11'b000_0010_0000,
    S_SUMW  = 11'b000_0100_0000,
    S_AVG   = 11'b000_1000_0000,
    S_DEV   = 11'b001_0000_0000,
    S_DEVW  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [wwpc_pkg::RAW_W-1:0]  tare_a_q, tare_b_q;
  logic [wwpc_pkg::GAIN_W-1:0] gain_a_q, gain_b_q;
  logic [GW-1:0]               unit_weight_q, min_weight_q, steady_limit_q, max_weight_q;
  logic                        cfg_wr;
  wwpc_pkg::reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = wwpc_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_a_q       <= '0;
      tare_b_q       <= '0;
      gain_a_q       <= wwpc_pkg::GAIN_W'(65536);
      gain_b_q       <= wwpc_pkg::GAIN_W'(65536);
      unit_weight_q  <= GW'(1000);
      min_weight_q   <= GW'(100);
      steady_limit_q <= GW'(50);
      max_weight_q   <= GW'(20000);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wwpc_pkg::REG_TARE_A:       tare_a_q       <= pwdata[wwpc_pkg::RAW_W-1:0];
        wwpc_pkg::REG_TARE_B:       tare_b_q       <= pwdata[wwpc_pkg::RAW_W-1:0];
        wwpc_pkg::REG_GAIN_A:       gain_a_q       <= pwdata[wwpc_pkg::GAIN_W-1:0];
        wwpc_pkg::REG_GAIN_B:       gain_b_q       <= pwdata[wwpc_pkg::GAIN_W-1:0];
        wwpc_pkg::REG_UNIT_WEIGHT:  unit_weight_q  <= pwdata[GW-1:0];
        wwpc_pkg::REG_MIN_WEIGHT:   min_weight_q   <= pwdata[GW-1:0];
        wwpc_pkg::REG_STEADY_LIMIT: steady_limit_q <= pwdata[GW-1:0];
        wwpc_pkg::REG_MAX_WEIGHT:   max_weight_q   <= pwdata[GW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      wwpc_pkg::REG_TARE_A:       prdata = wwpc_pkg::APB_DATA_W'(tare_a_q);
      wwpc_pkg::REG_TARE_B:       prdata = wwpc_pkg::APB_DATA_W'(tare_b_q);
      wwpc_pkg::REG_GAIN_A:       prdata = wwpc_pkg::APB_DATA_W'(gain_a_q);
      wwpc_pkg::REG_GAIN_B:       prdata = wwpc_pkg::APB_DATA_W'(gain_b_q);
      wwpc_pkg::REG_UNIT_WEIGHT:  prdata = wwpc_pkg::APB_DATA_W'(unit_weight_q);
      wwpc_pkg::REG_MIN_WEIGHT:   prdata = wwpc_pkg::APB_DATA_W'(min_weight_q);
      wwpc_pkg::REG_STEADY_LIMIT: prdata = wwpc_pkg::APB_DATA_W'(steady_limit_q);
      wwpc_pkg::REG_MAX_WEIGHT:   prdata = wwpc_pkg::APB_DATA_W'(max_weight_q);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_acc;
  logic   out_load;
  logic   out_valid_q;
  logic   div_busy;
  logic   idx_last;
  logic [SW-1:0] idx_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_load   = (state_q == S_FIN) & (~out_valid_q | ~out_stall_i);
  assign idx_last   = (idx_q == SW'(wwpc_pkg::WINDOW - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && sensors_ready_i) state_d = S_MULA;
      S_MULA:  state_d = S_MULB;
      S_MULB:  state_d = S_SATB;
      S_SATB:  state_d = S_WRITE;
      S_WRITE: state_d = S_SUM;
      S_SUM:   if (idx_last) state_d = S_SUMW;
      S_SUMW:  state_d = S_AVG;
      S_AVG:   state_d = S_DEV;
      S_DEV:   if (idx_last) state_d = S_DEVW;
      S_DEVW:  if (!div_busy) state_d = S_FIN;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Grams conversion: one shared multiplier, cell A then cell B
  // --------------------------------------------------------------------------
  logic signed [wwpc_pkg::RAW_W-1:0] raw_a_q, raw_b_q;
  logic signed [wwpc_pkg::RAW_W:0]   diff_a, diff_b, diff_sel;
  logic [wwpc_pkg::GAIN_W-1:0]       gain_sel;
  logic                              diff_pos;
  logic [wwpc_pkg::PROD_W-1:0]       prod_q;
  logic                              pos_q;
  logic [GW-1:0]                     grams;
  logic [GW-1:0]                     wa_q, wb_q;

  assign diff_a   = (wwpc_pkg::RAW_W+1)'(raw_a_q) - (wwpc_pkg::RAW_W+1)'(signed'(tare_a_q));
  assign diff_b   = (wwpc_pkg::RAW_W+1)'(raw_b_q) - (wwpc_pkg::RAW_W+1)'(signed'(tare_b_q));
  assign diff_sel = (state_q == S_MULA) ? diff_a : diff_b;
  assign gain_sel = (state_q == S_MULA) ? gain_a_q : gain_b_q;
  assign diff_pos = ~diff_sel[wwpc_pkg::RAW_W] & (diff_sel != '0);

  // Drop the fraction, saturate at full scale, zero for non-positive difference
  always_comb begin
    if (!pos_q) begin
      grams = '0;
    end else if (prod_q[wwpc_pkg::PROD_W-1:wwpc_pkg::FRAC_W+GW] != '0) begin
      grams = '1;
    end else begin
      grams = prod_q[wwpc_pkg::FRAC_W+GW-1:wwpc_pkg::FRAC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_a_q <= raw_sample_a_i;
      raw_b_q <= raw_sample_b_i;
    end
    if (state_q == S_MULA || state_q == S_MULB) begin
      prod_q <= diff_sel[wwpc_pkg::RAW_W-1:0] * gain_sel;
      pos_q  <= diff_pos;
    end
    if (state_q == S_MULB) wa_q <= grams;
    if (state_q == S_SATB) wb_q <= grams;
  end

  // --------------------------------------------------------------------------
  // Window memory. The write lands in S_WRITE before any walk read is issued,
  // so reads never overlap a pending write to the same entry.
  // --------------------------------------------------------------------------
  logic [TW-1:0]              win_mem [wwpc_pkg::WINDOW];
  logic [wwpc_pkg::WINDOW-1:0] win_vld_q;
  logic [SW-1:0]              slot_q;
  logic [TW-1:0]              rd_data_q;
  logic                       rd_vld_q;
  logic [TW-1:0]              entry;

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      win_mem[slot_q] <= TW'(wa_q) + TW'(wb_q);
    end
    rd_data_q <= win_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= '0;
      slot_q    <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= win_vld_q[idx_q];
      if (state_q == S_WRITE) begin
        win_vld_q[slot_q] <= 1'b1;
        slot_q <= (slot_q == SW'(wwpc_pkg::WINDOW - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

  assign entry = rd_vld_q ? rd_data_q : '0;

  // --------------------------------------------------------------------------
  // Window walks: sum, then maximum deviation from the average
  // --------------------------------------------------------------------------
  logic [wwpc_pkg::SUM_W-1:0] acc_q;
  logic [wwpc_pkg::SUM_W+wwpc_pkg::RECIP_W-1:0] avg_prod;
  logic [TW-1:0]              avg_q;
  logic [TW-1:0]              maxdev_q;
  logic [TW-1:0]              dev;
  logic                       acc_en_q, dev_en_q;
  logic                       div_start;
  logic [wwpc_pkg::SUM_W-1:0] div_dividend;
  logic [GW-1:0]              div_divisor;
  logic [wwpc_pkg::SUM_W-1:0] div_quot;

  assign dev      = (entry > avg_q) ? entry - avg_q : avg_q - entry;
  assign avg_prod = acc_q * wwpc_pkg::RECIP_W'(wwpc_pkg::AVG_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
      dev_en_q <= 1'b0;
    end else begin
      acc_en_q <= (state_q == S_SUM);
      dev_en_q <= (state_q == S_DEV);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE || state_q == S_AVG) begin
      idx_q <= '0;
    end else if (state_q == S_SUM || state_q == S_DEV) begin
      idx_q <= idx_last ? '0 : idx_q + 1'b1;
    end

    if (state_q == S_WRITE) begin
      acc_q <= '0;
    end else if (acc_en_q) begin
      acc_q <= acc_q + wwpc_pkg::SUM_W'(entry);
    end

    if (state_q == S_AVG) begin
      avg_q    <= avg_prod[wwpc_pkg::AVG_SHIFT +: TW];
      maxdev_q <= '0;
    end else if (dev_en_q && dev > maxdev_q) begin
      maxdev_q <= dev;
    end
  end

  // Divider: piece count, run during the deviation walk
  assign div_start    = (state_q == S_DEV) & (idx_q == '0);
  assign div_dividend = wwpc_pkg::SUM_W'(avg_q);
  assign div_divisor  = unit_weight_q;

  wwpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // --------------------------------------------------------------------------
  // Result assembly
  // --------------------------------------------------------------------------
  logic [wwpc_pkg::COUNT_W-1:0]        prev_count_q;
  logic                                above_min;
  logic [wwpc_pkg::COUNT_W-1:0]        count;
  logic [TW-1:0]                       avg_kept;
  logic                                stable;
  logic signed [wwpc_pkg::CHANGE_W-1:0] change;
  logic [1:0]                          status;
  logic                                over;
  logic [GW-1:0]                       avg_out;

  assign above_min = avg_q > TW'(min_weight_q);
  assign stable    = maxdev_q < TW'(steady_limit_q);
  assign avg_kept  = above_min ? avg_q : '0;
  assign over      = avg_kept > TW'(max_weight_q);
  assign avg_out   = over ? max_weight_q : avg_kept[GW-1:0];

  always_comb begin
    if (!above_min) begin
      count = '0;
    end else if (div_quot[wwpc_pkg::SUM_W-1:wwpc_pkg::COUNT_W] != '0) begin
      count = '1;
    end else begin
      count = div_quot[wwpc_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    change = '0;
    status = stable ? wwpc_pkg::STATUS_STABLE : wwpc_pkg::STATUS_MEASURING;
    if (stable && count != prev_count_q) begin
      change = signed'({1'b0, count}) - signed'({1'b0, prev_count_q});
      status = (count > prev_count_q) ? wwpc_pkg::STATUS_ADDED : wwpc_pkg::STATUS_REMOVED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        prev_count_q <= count;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cell_weight_a_o  <= wa_q;
      cell_weight_b_o  <= wb_q;
      average_weight_o <= avg_out;
      piece_count_o    <= count;
      steady_o         <= stable;
      status_o         <= status;
      count_change_o   <= change;
      over_capacity_o  <= over;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/wwpc_div.sv
// ----------------------------------------------------------------------------
// wwpc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module wwpc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wwpc_pkg::SUM_W-1:0]    dividend_i,
  input  logic [wwpc_pkg::GRAM_W-1:0]   divisor_i,
  output logic                          busy_o,
  output logic [wwpc_pkg::SUM_W-1:0]    quot_o
);

  logic                            busy_q;
  logic [wwpc_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [wwpc_pkg::GRAM_W-1:0]     rem_q;
  logic [wwpc_pkg::GRAM_W-1:0]     dvs_q;
  logic [wwpc_pkg::SUM_W-1:0]      quo_q;

  logic [wwpc_pkg::GRAM_W:0]       trial;
  logic [wwpc_pkg::GRAM_W:0]       diff;
  logic                            ge;

  assign trial = {rem_q, quo_q[wwpc_pkg::SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= wwpc_pkg::DIV_CNT_W'(wwpc_pkg::SUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == wwpc_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[wwpc_pkg::GRAM_W-1:0] : trial[wwpc_pkg::GRAM_W-1:0];
      quo_q <= {quo_q[wwpc_pkg::SUM_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule
